### rtl/run_page_allocator_core_assert.svh
// Assertion macros used by the checker file of the run page allocator.
`ifndef RUN_PAGE_ALLOCATOR_CORE_ASSERT_SVH
`define RUN_PAGE_ALLOCATOR_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define RPA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define RPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/rpa_pkg.sv
`timescale 1ns / 1ps

package rpa_pkg;

  // Field widths
  localparam int ADDR_W    = 32;
  localparam int PAGE_W    = 11;
  localparam int OWNER_W   = 16;
  localparam int PSL_W     = 5;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 2;

  // Operation and kind codes
  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_FREE    = 1'b1;
  localparam logic KIND_HEAP  = 1'b0;
  localparam logic KIND_STACK = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NULL   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_ABSENT = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_TOP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STACK_ADDR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SHIFT = 2'd2;

  localparam logic [PSL_W-1:0] PSL_RESET = 5'd12;

  // One run table entry
  typedef struct packed {
    logic               kind;
    logic               freed;
    logic [ADDR_W-1:0]  address;
    logic [PAGE_W-1:0]  pages;
    logic [OWNER_W-1:0] owner;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic start;   // latch request, clear walk state
    logic walk;    // step the table walk
    logic shift;   // scale page offset to bytes
    logic calc;    // form run address
    logic commit;  // update table and counters, load result
  } rpa_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic skip;       // request answered without a walk
    logic is_free;    // request is a free
    logic walk_done;  // walk found a hit or ran past the last entry
  } rpa_stat_t;

endpackage

### rtl/rpa_ctrl.sv
`timescale 1ns / 1ps

module rpa_ctrl
  import rpa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  rpa_stat_t st,
  output rpa_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_SHIFT,
    ST_ADDR,
    ST_COMMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_stall_r, in_stall_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;

  // Sequence one request at a time
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && !in_stall_r) begin
          cmd.start = 1'b1;
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (st.skip) begin
          state_nxt = ST_COMMIT;
        end else begin
          cmd.walk = 1'b1;
          if (st.walk_done) begin
            state_nxt = st.is_free ? ST_COMMIT : ST_SHIFT;
          end
        end
      end
      ST_SHIFT: begin
        cmd.shift = 1'b1;
        state_nxt = ST_ADDR;
      end
      ST_ADDR: begin
        cmd.calc  = 1'b1;
        state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold the result until the receiver takes it
  assign out_valid_nxt = cmd.commit ? 1'b1 : (out_valid_r && out_stall);
  assign in_stall_nxt  = (state_nxt != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      in_stall_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_stall_r  <= in_stall_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = in_stall_r;
  assign out_valid = out_valid_r;

endmodule

### rtl/rpa_datapath.sv
`timescale 1ns / 1ps

module rpa_datapath
  import rpa_pkg::*;
#(
  parameter int TABLE_ENTRIES = 64,
  parameter int MAX_PAGES     = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rpa_cmd_t             cmd,
  output rpa_stat_t            st,
  input  logic                 in_operation,
  input  logic                 in_run_kind,
  input  logic [PAGE_W-1:0]    in_page_count,
  input  logic [ADDR_W-1:0]    in_run_address,
  input  logic [OWNER_W-1:0]   in_owner_id,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_wdata,
  output logic [ADDR_W-1:0]    out_result_address,
  output logic [STATUS_W-1:0]  out_status
);

  localparam int IDX_W   = $clog2(TABLE_ENTRIES);
  localparam int USED_W  = $clog2(TABLE_ENTRIES + 1);
  localparam int PG_W    = $clog2(MAX_PAGES + 1);
  localparam int BELOW_W = $clog2(MAX_PAGES + (1 << PAGE_W));

  // Run table
  entry_t mem [TABLE_ENTRIES];

  // Configuration registers
  logic [ADDR_W-1:0] heap_top_r;
  logic [ADDR_W-1:0] stack_addr_r;
  logic [PSL_W-1:0]  page_shift_r;

  // Request
  logic               req_op_r;
  logic               req_kind_r;
  logic [PAGE_W-1:0]  req_count_r;
  logic [ADDR_W-1:0]  req_addr_r;
  logic [OWNER_W-1:0] req_owner_r;

  // Walk state
  logic [USED_W-1:0]  rd_idx_r;
  logic               chk_valid_r;
  logic [IDX_W-1:0]   chk_idx_r;
  logic               hit_r;
  logic [IDX_W-1:0]   slot_r;
  entry_t             rd_q_r;
  logic [BELOW_W-1:0] below_r;

  // Address and counters
  logic [ADDR_W-1:0]  bytes_r;
  logic [ADDR_W-1:0]  addr_r;
  logic [USED_W-1:0]  entries_used_r;
  logic [PG_W-1:0]    pages_used_r;

  // Result
  logic [ADDR_W-1:0]   out_addr_r;
  logic [STATUS_W-1:0] out_status_r;

  logic               skip;
  logic               match;
  logic               chk_hit;
  logic               chk_add;
  logic               issue;
  logic [BELOW_W-1:0] sum_pages;
  logic [BELOW_W-1:0] pages_total;
  logic               full;
  logic               append;
  logic               mem_we;
  logic [IDX_W-1:0]   wr_idx;
  entry_t             wr_data;
  logic [ADDR_W-1:0]  res_addr_nxt;
  logic [STATUS_W-1:0] res_status_nxt;

  // Decode request and walk step
  always_comb begin
    if (req_op_r == OP_FREE) begin
      skip  = (req_addr_r == '0) || (req_count_r == '0);
      match = (rd_q_r.address == req_addr_r) && (rd_q_r.pages == req_count_r);
    end else begin
      skip  = (req_count_r == '0);
      match = rd_q_r.freed && (rd_q_r.kind == req_kind_r) && (rd_q_r.pages == req_count_r);
    end
    chk_hit = cmd.walk && chk_valid_r && !hit_r && match;
    chk_add = cmd.walk && chk_valid_r && !hit_r && !match && (rd_q_r.kind == req_kind_r);
    issue   = cmd.walk && !hit_r && !chk_hit && (rd_idx_r != entries_used_r);
  end

  assign st.skip      = skip;
  assign st.is_free   = (req_op_r == OP_FREE);
  assign st.walk_done = hit_r || ((rd_idx_r == entries_used_r) && !chk_valid_r);

  // Room check and commit decision
  assign sum_pages   = below_r + BELOW_W'(req_count_r);
  assign pages_total = BELOW_W'(pages_used_r) + BELOW_W'(req_count_r);
  assign full        = (entries_used_r == USED_W'(TABLE_ENTRIES)) ||
                       (pages_total > BELOW_W'(MAX_PAGES));

  always_comb begin
    mem_we         = 1'b0;
    append         = 1'b0;
    wr_idx         = slot_r;
    wr_data        = rd_q_r;
    res_addr_nxt   = '0;
    res_status_nxt = STATUS_OK;
    if (req_op_r == OP_FREE) begin
      wr_data.freed = 1'b1;
      if (!skip && hit_r) begin
        mem_we = 1'b1;
      end else begin
        res_status_nxt = STATUS_ABSENT;
      end
    end else begin
      wr_data.kind    = req_kind_r;
      wr_data.freed   = 1'b0;
      wr_data.address = addr_r;
      wr_data.pages   = req_count_r;
      wr_data.owner   = req_owner_r;
      if (skip) begin
        res_status_nxt = STATUS_NULL;
      end else if (hit_r) begin
        mem_we       = 1'b1;
        res_addr_nxt = addr_r;
      end else if (full) begin
        res_status_nxt = STATUS_FULL;
      end else begin
        mem_we       = 1'b1;
        append       = 1'b1;
        wr_idx       = entries_used_r[IDX_W-1:0];
        res_addr_nxt = addr_r;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_top_r     <= '0;
      stack_addr_r   <= '0;
      page_shift_r   <= PSL_RESET;
      rd_idx_r       <= '0;
      chk_valid_r    <= 1'b0;
      hit_r          <= 1'b0;
      entries_used_r <= '0;
      pages_used_r   <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_HEAP_TOP:   heap_top_r   <= cfg_wdata;
          CFG_STACK_ADDR: stack_addr_r <= cfg_wdata;
          CFG_PAGE_SHIFT: page_shift_r <= cfg_wdata[PSL_W-1:0];
          default: ;
        endcase
      end
      if (cmd.start) begin
        rd_idx_r    <= '0;
        chk_valid_r <= 1'b0;
        hit_r       <= 1'b0;
      end else if (cmd.walk) begin
        if (issue) begin
          rd_idx_r <= rd_idx_r + USED_W'(1);
        end
        chk_valid_r <= issue;
        if (chk_hit) begin
          hit_r <= 1'b1;
        end
      end
      if (cmd.commit && append) begin
        entries_used_r <= entries_used_r + USED_W'(1);
        pages_used_r   <= pages_total[PG_W-1:0];
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_op_r    <= in_operation;
      req_kind_r  <= in_run_kind;
      req_count_r <= in_page_count;
      req_addr_r  <= in_run_address;
      req_owner_r <= in_owner_id;
      below_r     <= '0;
    end else if (chk_add) begin
      below_r <= below_r + BELOW_W'(rd_q_r.pages);
    end
    if (issue) begin
      chk_idx_r <= rd_idx_r[IDX_W-1:0];
    end
    if (chk_hit) begin
      slot_r <= chk_idx_r;
    end
    if (cmd.shift) begin
      bytes_r <= ADDR_W'(sum_pages) << page_shift_r;
    end
    if (cmd.calc) begin
      addr_r <= (req_kind_r == KIND_STACK) ? stack_addr_r : (heap_top_r - bytes_r);
    end
    if (cmd.commit) begin
      out_addr_r   <= res_addr_nxt;
      out_status_r <= res_status_nxt;
    end
  end

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.commit && mem_we) begin
      mem[wr_idx] <= wr_data;
    end
    if (issue) begin
      rd_q_r <= mem[rd_idx_r[IDX_W-1:0]];
    end
  end

  assign out_result_address = out_addr_r;
  assign out_status         = out_status_r;

endmodule

### rtl/run_page_allocator_core.sv
// Run page allocator: a table of allocation runs with a running page total.
// Input channel (in_valid / in_stall) carries one request: allocate or free a
// run, with kind, page count, address and owner. Result channel (out_valid /
// out_stall) returns one transfer per request: result address and status.
// Configuration writes (cfg_we, cfg_index, cfg_wdata) set heap top, stack
// address and page shift; write them only while no request is in flight.
// Each request walks the used part of the run table, one entry per cycle
// through the table memory's single registered read port. An allocate then
// passes the shift, address and commit states; a free goes from the walk
// straight to commit. An allocate that reuses a freed run, or a free that
// matches, stops the walk early; a request answered without a walk (zero
// pages, or a free of address 0) goes straight to commit. One request is in
// flight at a time: a new one is taken only after the last has committed.
// The finished result sits in an output register; when the receiver stalls
// it holds there and the next request may still be taken and walked, but it
// cannot finish until the held result is transferred.
// Reset (rst_n low, synchronous) empties the table and page total and loads
// the default configuration: heap top 0, stack address 0, page shift 12.
`timescale 1ns / 1ps

module run_page_allocator_core
  import rpa_pkg::*;
#(
  parameter int TABLE_ENTRIES = 64,
  parameter int MAX_PAGES     = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_operation,
  input  logic                 in_run_kind,
  input  logic [PAGE_W-1:0]    in_page_count,
  input  logic [ADDR_W-1:0]    in_run_address,
  input  logic [OWNER_W-1:0]   in_owner_id,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [ADDR_W-1:0]    out_result_address,
  output logic [STATUS_W-1:0]  out_status,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_wdata
);

  rpa_cmd_t  cmd;
  rpa_stat_t st;

  rpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  rpa_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .MAX_PAGES     (MAX_PAGES)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .st                 (st),
    .in_operation       (in_operation),
    .in_run_kind        (in_run_kind),
    .in_page_count      (in_page_count),
    .in_run_address     (in_run_address),
    .in_owner_id        (in_owner_id),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .out_result_address (out_result_address),
    .out_status         (out_status)
  );

endmodule

### rtl/rpa_checker.sv
`timescale 1ns / 1ps
`include "run_page_allocator_core_assert.svh"

module rpa_checker
  import rpa_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic [ADDR_W-1:0]   out_result_address,
  input logic [STATUS_W-1:0] out_status
);

  // Only one request in flight: busy right after a transfer in
  `RPA_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "not busy after accept")

  // Any status but ok carries a null address
  `RPA_ASSERT_NOW(a_null_on_error, out_valid && (out_status != STATUS_OK), out_result_address == '0, "error result with nonzero address")

  // A new result appears only as the block leaves its busy phase
  `RPA_ASSERT_NOW(a_result_from_busy, $rose(out_valid), $past(in_stall), "result without a request in flight")

  // Hold a stalled result
  `RPA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_result_address) && $stable(out_status), "stalled result changed")

endmodule

bind run_page_allocator_core rpa_checker u_rpa_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_result_address (out_result_address),
  .out_status         (out_status)
);
